@@ design/mmf_pkg.sv @@
// Shared types and constants for the windowed mean/median pixel filter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package mmf_pkg;

  // Fixed limits and register widths.
  localparam int MAX_HEIGHT = 4096;
  localparam int HW         = 13;   // height value width (0..4096)
  localparam int RLW        = 12;   // row index width (0..4095)
  localparam int WIDTH_W    = 11;
  localparam int WIN_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the config port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 3'd3;

  // Register reset values.
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [HW-1:0]      HEIGHT_RESET = 13'd1;
  localparam logic [WIN_W-1:0]   WIN_RESET    = 3'd3;

  // Input word action codes.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic reduce_start;
    logic reduce_step;
    logic finish;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic emit;
    logic scan_last;
    logic reduce_done;
    logic out_free;
  } sts_t;

endpackage

@@ design/windowed_mean_median_pixel_filter.sv @@
// RGB pixels go in in raster order and filtered pixels come out in raster
// order, each channel the mean or the median over an n-by-n window clipped
// at the image edges. Output lags input by L*width+L words (L = n-1-n/2);
// once the image is complete, flush words (or surplus pixels) drain the rest.
// One word at a time: a word that releases no result is accepted and checked;
// one that does also runs a window scan (one line-store read per position),
// a drain state, then the reduce loop: restoring division for the mean (one
// quotient bit per cycle) or shift steps down the sorted slots for the median,
// and last the output register load (held off while a previous result is
// still held by out_stall_i).
// The line store has no clearing pass after reset.
// Depends on mmf_pkg, mmf_ctrl, mmf_datapath.
`timescale 1ns / 1ps

module windowed_mean_median_pixel_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mmf_pkg::pix_in_t               in_word_i,
  // filtered output words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mmf_pkg::pix_out_t              out_word_o,
  // register writes; any write to a defined register restarts the frame
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mmf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // registers are always writable; writes are to be made only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  mmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // the output register is never loaded over a word still waiting
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("output register overwritten");

  // an accepted word keeps the block busy for at least the check cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted two words back to back");

  // a new result only appears after the block worked on a word
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without processing");

endmodule

@@ design/mmf_store.sv @@
// Line store: single write port, single registered read port.
// Depends on mmf_pkg (rgb_t).
`timescale 1ns / 1ps

module mmf_store #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  mmf_pkg::rgb_t        wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output mmf_pkg::rgb_t        rd_data_o
);
  import mmf_pkg::*;

  rgb_t mem_q [DEPTH];
  rgb_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/mmf_sort.sv @@
// Insertion-sort slot row for one 8-bit channel, with a shift-down for
// picking the middle entries. Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_sort #(
  parameter int NCELL = 49,
  parameter int CW    = 6
) (
  input  logic          clk_i,
  input  logic          insert_i,
  input  logic          shift_i,
  input  logic [CW-1:0] k_i,
  input  logic [7:0]    value_i,
  output logic [7:0]    s0_o,
  output logic [7:0]    s1_o
);
  import mmf_pkg::*;

  logic [7:0] slot_q   [NCELL];
  logic [7:0] slot_d   [NCELL];
  logic       gt       [NCELL];
  logic       lower_gt [NCELL];
  logic [7:0] prev_val [NCELL];
  logic [7:0] next_val [NCELL];

  // gt: slot is empty or holds a larger value than the one coming in
  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      gt[i] = (CW'(i) >= k_i) || (slot_q[i] > value_i);
    end
    lower_gt[0] = 1'b0;
    prev_val[0] = value_i;
    for (int i = 1; i < NCELL; i++) begin
      lower_gt[i] = gt[i-1];
      prev_val[i] = slot_q[i-1];
    end
    for (int i = 0; i < NCELL - 1; i++) begin
      next_val[i] = slot_q[i+1];
    end
    next_val[NCELL-1] = slot_q[NCELL-1];
  end

  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      slot_d[i] = slot_q[i];
      if (insert_i && gt[i]) begin
        slot_d[i] = lower_gt[i] ? prev_val[i] : value_i;
      end else if (shift_i) begin
        slot_d[i] = next_val[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NCELL; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign s0_o = slot_q[0];
  assign s1_o = slot_q[1];

endmodule

@@ design/mmf_datapath.sv @@
// Datapath: config registers, raster counters, window scan, line store,
// accumulate / sort, serial divider and output register.
// Depends on mmf_pkg, mmf_store, mmf_sort.
`timescale 1ns / 1ps

module mmf_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mmf_pkg::cmd_t                      cmd_i,
  output mmf_pkg::sts_t                      sts_o,
  input  mmf_pkg::pix_in_t                   in_word_i,
  input  logic                               cfg_we_i,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mmf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output mmf_pkg::pix_out_t                  out_word_o
);
  import mmf_pkg::*;

  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int XW    = CLW + 2;
  localparam int YW    = RLW + 2;
  localparam int LINW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int CW    = $clog2(NCELL + 1);
  localparam int SW    = $clog2(NCELL * 255 + 1);
  localparam int HALFC = NCELL / 2;
  localparam int RCW   = $clog2(((SW > HALFC) ? SW : HALFC) + 1);

  // ---------------- config ----------------
  logic [WIDTH_W-1:0] width_q;
  logic [HW-1:0]      height_q;
  logic [WIN_W-1:0]   win_q;
  logic               mode_q;
  logic               cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i <= CFG_FILTER_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      win_q    <= WIN_RESET;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HW-1:0];
        CFG_WINDOW_SIZE:  win_q    <= cfg_data_i[WIN_W-1:0];
        CFG_FILTER_MODE:  mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [NW-1:0] n_eff, half, lrows;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (height_q > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    if (win_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(win_q);
    end
    half  = n_eff >> 1;
    lrows = n_eff - NW'(1) - half;
  end

  logic [NW+WW-1:0] lag_prod, hoff_prod;
  logic [WW+HW-1:0] total_prod;
  logic [LINW-1:0]  lag_q, total_q;
  logic [AW-1:0]    hoff_q;

  assign lag_prod   = (NW+WW)'(lrows) * (NW+WW)'(w_eff);
  assign hoff_prod  = (NW+WW)'(half) * (NW+WW)'(w_eff);
  assign total_prod = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);

  // products registered; they only move on a config write
  always_ff @(posedge clk_i) begin
    lag_q   <= LINW'(lag_prod) + LINW'(lrows);
    hoff_q  <= AW'(hoff_prod) + AW'(half);
    total_q <= LINW'(total_prod);
  end

  // ---------------- input raster ----------------
  logic [CLW-1:0]  in_col_q;
  logic [RLW-1:0]  in_row_q;
  logic [LINW-1:0] in_lin_q;
  logic [AW-1:0]   wr_addr_q;
  logic            done_q;
  logic            write_en;
  logic            restart;
  logic            last;

  assign write_en = cmd_i.accept && (in_word_i.action == ACT_PIXEL) && !done_q;
  assign restart  = cfg_hit || (cmd_i.finish && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_lin_q  <= '0;
      wr_addr_q <= '0;
      done_q    <= 1'b0;
    end else if (restart) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_lin_q  <= '0;
      wr_addr_q <= '0;
      done_q    <= 1'b0;
    end else if (write_en) begin
      if ((WW'(in_col_q) + WW'(1)) == w_eff) begin
        in_col_q <= '0;
        if ((HW'(in_row_q) + HW'(1)) == h_eff) begin
          in_row_q <= '0;
          done_q   <= 1'b1;
        end else begin
          in_row_q <= in_row_q + RLW'(1);
        end
      end else begin
        in_col_q <= in_col_q + CLW'(1);
      end
      in_lin_q  <= in_lin_q + LINW'(1);
      wr_addr_q <= (wr_addr_q == AW'(DEPTH - 1)) ? '0 : wr_addr_q + AW'(1);
    end
  end

  // ---------------- output raster ----------------
  logic [CLW-1:0]  out_col_q;
  logic [RLW-1:0]  out_row_q;
  logic [LINW-1:0] out_lin_q;
  logic [AW-1:0]   out_addr_q;

  assign last = (out_lin_q == total_q - LINW'(1));

  assign sts_o.emit = done_q ||
    ((LINW+1)'(in_lin_q) >=
     (LINW+1)'(out_lin_q) + (LINW+1)'(lag_q) + (LINW+1)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_lin_q  <= '0;
      out_addr_q <= '0;
    end else if (restart) begin
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_lin_q  <= '0;
      out_addr_q <= '0;
    end else if (cmd_i.finish) begin
      if ((WW'(out_col_q) + WW'(1)) == w_eff) begin
        out_col_q <= '0;
        out_row_q <= out_row_q + RLW'(1);
      end else begin
        out_col_q <= out_col_q + CLW'(1);
      end
      out_lin_q  <= out_lin_q + LINW'(1);
      out_addr_q <= (out_addr_q == AW'(DEPTH - 1)) ? '0 : out_addr_q + AW'(1);
    end
  end

  // ---------------- window scan ----------------
  logic [NW-1:0] dx_q, dy_q;
  logic [XW-1:0] x_q, x_init;
  logic [YW-1:0] y_q, y_init;
  logic [AW-1:0] rbase_q, addr_q, base_init, rbase_next, addr_inc;
  logic [AW:0]   base_diff, rsum;
  logic          row_end, x_ok, y_ok, rd_en, rd_vld_q;

  assign x_init    = XW'(out_col_q) - XW'(half);
  assign y_init    = YW'(out_row_q) - YW'(half);
  assign base_diff = {1'b0, out_addr_q} - {1'b0, hoff_q};
  assign base_init = base_diff[AW] ? AW'(base_diff + (AW+1)'(DEPTH)) : base_diff[AW-1:0];
  assign rsum      = {1'b0, rbase_q} + (AW+1)'(w_eff);
  assign rbase_next = (rsum >= (AW+1)'(DEPTH)) ? AW'(rsum - (AW+1)'(DEPTH)) : rsum[AW-1:0];
  assign addr_inc  = (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);

  assign row_end = (dx_q == n_eff - NW'(1));
  assign sts_o.scan_last = row_end && (dy_q == n_eff - NW'(1));

  // sign bit clear and below the image edge
  assign x_ok  = !x_q[XW-1] && (x_q[XW-2:0] < (XW-1)'(w_eff));
  assign y_ok  = !y_q[YW-1] && (y_q[YW-2:0] < h_eff);
  assign rd_en = cmd_i.scan_step && x_ok && y_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      dx_q    <= '0;
      dy_q    <= '0;
      x_q     <= x_init;
      y_q     <= y_init;
      rbase_q <= base_init;
      addr_q  <= base_init;
    end else if (cmd_i.scan_step) begin
      if (row_end) begin
        dx_q    <= '0;
        dy_q    <= dy_q + NW'(1);
        x_q     <= x_init;
        y_q     <= y_q + YW'(1);
        rbase_q <= rbase_next;
        addr_q  <= rbase_next;
      end else begin
        dx_q   <= dx_q + NW'(1);
        x_q    <= x_q + XW'(1);
        addr_q <= addr_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
    end
  end

  rgb_t wr_pix, rd_pix;
  assign wr_pix = '{red: in_word_i.in_red, green: in_word_i.in_green,
                    blue: in_word_i.in_blue};

  mmf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (write_en),
    .wr_addr_i (wr_addr_q),
    .wr_data_i (wr_pix),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_pix)
  );

  // ---------------- accumulate, sort, divide ----------------
  logic [7:0]    ch_val [3];
  logic [7:0]    s0     [3];
  logic [7:0]    s1     [3];
  logic [SW-1:0] sum_q  [3];
  logic [CW-1:0] rem_q  [3];
  logic [SW-1:0] quot_q [3];
  logic [CW:0]   dv_t   [3];
  logic          dv_ge  [3];
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] med_shift;
  logic [RCW-1:0] red_q;
  logic [8:0]    mid    [3];
  logic [7:0]    res    [3];

  assign ch_val[0] = rd_pix.red;
  assign ch_val[1] = rd_pix.green;
  assign ch_val[2] = rd_pix.blue;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    mmf_sort #(
      .NCELL (NCELL),
      .CW    (CW)
    ) u_sort (
      .clk_i    (clk_i),
      .insert_i (rd_vld_q),
      .shift_i  (cmd_i.reduce_step && mode_q),
      .k_i      (cnt_q),
      .value_i  (ch_val[c]),
      .s0_o     (s0[c]),
      .s1_o     (s1[c])
    );
  end

  // one restoring-division bit per step
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dv_t[c]  = {rem_q[c], quot_q[c][SW-1]};
      dv_ge[c] = dv_t[c] >= (CW+1)'(cnt_q);
      mid[c]   = 9'(s0[c]) + 9'(s1[c]);
      if (mode_q) begin
        res[c] = cnt_q[0] ? s0[c] : mid[c][8:1];
      end else begin
        res[c] = quot_q[c][7:0];
      end
    end
  end

  assign med_shift = (cnt_q - CW'(1)) >> 1;
  assign sts_o.reduce_done = mode_q ? (red_q == RCW'(med_shift)) : (red_q == RCW'(SW));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      cnt_q <= '0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
      end
    end else if (rd_vld_q) begin
      cnt_q <= cnt_q + CW'(1);
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_q[c] + SW'(ch_val[c]);
      end
    end
    if (cmd_i.reduce_start) begin
      red_q <= '0;
      for (int c = 0; c < 3; c++) begin
        rem_q[c]  <= '0;
        quot_q[c] <= sum_q[c];
      end
    end else if (cmd_i.reduce_step) begin
      red_q <= red_q + RCW'(1);
      if (!mode_q) begin
        for (int c = 0; c < 3; c++) begin
          rem_q[c]  <= dv_ge[c] ? CW'(dv_t[c] - (CW+1)'(cnt_q)) : CW'(dv_t[c]);
          quot_q[c] <= {quot_q[c][SW-2:0], dv_ge[c]};
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic     out_valid_q;
  pix_out_t out_word_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_q <= '{out_red: res[0], out_green: res[1], out_blue: res[2],
                      frame_end: last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ design/mmf_ctrl.sv @@
// Controller FSM: sequences accept, window scan, reduce and output load.
// Depends on mmf_pkg (cmd_t, sts_t).
`timescale 1ns / 1ps

module mmf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mmf_pkg::sts_t sts_i,
  output mmf_pkg::cmd_t cmd_o
);
  import mmf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PREP   = 3'd4;
  localparam logic [2:0] S_REDUCE = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.emit) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_PREP;   // last read word lands in the sums
      S_PREP: begin
        cmd_o.reduce_start = 1'b1;
        state_d            = S_REDUCE;
      end
      S_REDUCE: begin
        if (sts_i.reduce_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.reduce_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ test/windowed_mean_median_pixel_filter_tb.sv @@
// Self-checking testbench for the windowed mean/median pixel filter: a short
// table of directed words, then random frames; a predictor or a set result checks each.
// Depends on mmf_pkg and windowed_mean_median_pixel_filter.
`timescale 1ns / 1ps

module windowed_mean_median_pixel_filter_tb;
  import mmf_pkg::*;

  localparam int STORE_DEPTH = 7 * 1024;
  localparam int SETTLE      = 150;   // cycles for a word that releases no result
  localparam int IDLE_LIMIT  = 5000;  // watchdog: cycles with no transfer on any port
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef int win_vals_t[49];

  // one row of the directed table: a register write or a pixel/flush word
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    pix_in_t              wd;
    bit                   typed;
    pix_out_t             want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pix_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pix_out_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  windowed_mean_median_pixel_filter DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // ---------------- filter predictor ----------------
  rgb_t         line_mem [STORE_DEPTH];
  logic [10:0]  reg_width;
  logic [12:0]  reg_height;
  logic [2:0]   reg_window;
  logic         reg_mode;
  int unsigned  row_in, col_in, row_out, col_out;
  bit           image_taken;

  pix_out_t     filtered_q[$];    // filtered words still owed by the DUT
  int           errors = 0;
  int           words_in = 0;
  int           words_out = 0;
  int           reg_writes = 0;
  bit           frame_closed;     // predictor released a frame_end word
  bit           calm = 1'b0;      // no idling on either side

  function automatic void restart_image();
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
    image_taken = 1'b0;
  endfunction

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    return (reg_width > 1024) ? 1024 : reg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height == 0) return 1;
    return (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
  endfunction

  // mean, or median with even counts averaging the two middle values
  function automatic logic [7:0] chan_reduce(win_vals_t v, int cnt);
    int sum, t, j;
    sum = 0;
    if (cnt == 0) return 8'd0;
    if (reg_mode == 1'b0) begin
      for (int i = 0; i < cnt; i++) sum += v[i];
      return 8'(sum / cnt);
    end
    for (int i = 1; i < cnt; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    if (cnt % 2) return 8'(v[cnt/2]);
    return 8'((v[cnt/2-1] + v[cnt/2]) / 2);
  endfunction

  function automatic bit filter_word(input pix_in_t wd, output pix_out_t res);
    int unsigned w, h, n, half, lag_rows, lag, total, taken, pos;
    int r0, c0, y, x, cnt;
    rgb_t px;
    win_vals_t vr, vg, vb;
    w = eff_width();
    h = eff_height();
    n = (reg_window == 0) ? 1 : reg_window;
    half = n / 2;
    lag_rows = n - 1 - half;
    lag = lag_rows * w + lag_rows;
    total = w * h;
    cnt = 0;
    res = '0;
    if (col_in >= w || row_in >= h || col_out >= w || row_out >= h) restart_image();
    if (wd.action == ACT_PIXEL && !image_taken) begin
      line_mem[(row_in * w + col_in) % STORE_DEPTH] = '{wd.in_red, wd.in_green, wd.in_blue};
      col_in++;
      if (col_in == w) begin
        col_in = 0;
        row_in++;
        if (row_in == h) begin
          row_in = 0;
          image_taken = 1'b1;
        end
      end
    end
    taken = image_taken ? total : row_in * w + col_in;
    pos = row_out * w + col_out;
    if (!image_taken && taken < pos + lag + 1) return 1'b0;
    r0 = int'(row_out) - int'(half);
    c0 = int'(col_out) - int'(half);
    for (int dy = 0; dy < n; dy++) begin
      y = r0 + dy;
      if (y < 0 || y >= int'(h)) continue;
      for (int dx = 0; dx < n; dx++) begin
        x = c0 + dx;
        if (x < 0 || x >= int'(w)) continue;
        px = line_mem[(y * w + x) % STORE_DEPTH];
        vr[cnt] = px.red;
        vg[cnt] = px.green;
        vb[cnt] = px.blue;
        cnt++;
      end
    end
    res.out_red   = chan_reduce(vr, cnt);
    res.out_green = chan_reduce(vg, cnt);
    res.out_blue  = chan_reduce(vb, cnt);
    res.frame_end = (pos == total - 1);
    if (res.frame_end) restart_image();
    else begin
      col_out++;
      if (col_out == w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------- drivers ----------------
  // all tasks are entered right after a rising edge
  task automatic send_word(input pix_in_t wd, input bit typed = 1'b0,
                           input pix_out_t want = '0);
    pix_out_t res;
    bit got;
    in_word_i  <= wd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    got = filter_word(wd, res);
    if (typed) begin
      got = 1'b1;
      res = want;
    end
    if (got) begin
      filtered_q.push_back(res);
      if (res.frame_end) frame_closed = 1'b1;
    end
    words_in++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // drains the DUT, then lets a word that released nothing finish too
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    wait_quiet();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_IMAGE_WIDTH:  reg_width  = data[10:0];
      CFG_IMAGE_HEIGHT: reg_height = data[12:0];
      CFG_WINDOW_SIZE:  reg_window = data[2:0];
      CFG_FILTER_MODE:  reg_mode   = data[0];
      default:          return;
    endcase
    restart_image();
  endtask

  // one setting, then whole frames or one frame cut short (at most 63 pixels)
  task automatic run_phase(input int w, input int h, input int n, input int m,
                           input int frames, input bit cut_short);
    int unsigned tot, cnt;
    pix_in_t wd;
    write_reg(CFG_IMAGE_WIDTH,  {5'($urandom), 11'(w)});
    write_reg(CFG_IMAGE_HEIGHT, {3'($urandom), 13'(h)});
    write_reg(CFG_WINDOW_SIZE,  {13'($urandom), 3'(n)});
    write_reg(CFG_FILTER_MODE,  {15'($urandom), 1'(m)});
    tot = eff_width() * eff_height();
    for (int f = 0; f < frames; f++) begin
      frame_closed = 1'b0;
      cnt = cut_short ? $urandom_range(0, ((tot > 64) ? 64 : tot) - 1) : tot;
      for (int unsigned i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          wd = pix_in_t'($urandom);
          wd.action = ACT_FLUSH;
          send_word(wd);   // early flush: must release nothing
        end
        wd = pix_in_t'($urandom);
        wd.action = ACT_PIXEL;
        send_word(wd);
      end
      // drain with flushes and surplus pixels until the frame closes
      while (!cut_short && !frame_closed) begin
        wd = pix_in_t'($urandom);
        wd.action = ($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_FLUSH;
        send_word(wd);
      end
    end
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    pix_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual r=%h g=%h b=%h end=%b",
                 $time, out_word_o.out_red, out_word_o.out_green, out_word_o.out_blue,
                 out_word_o.frame_end);
      end else begin
        e = filtered_q.pop_front();
        if (out_word_o !== e) begin
          errors++;
          $display("%0t: mismatch, expected r=%h g=%h b=%h end=%b, actual r=%h g=%h b=%h end=%b",
                   $time, e.out_red, e.out_green, e.out_blue, e.frame_end,
                   out_word_o.out_red, out_word_o.out_green, out_word_o.out_blue,
                   out_word_o.frame_end);
        end
      end
    end
  end

  // receiver stalls in random bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (calm) out_stall_i <= 1'b0;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  // watchdog on cycles in which nothing moves
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time, filtered_q.size());
      $display("FAIL windowed_mean_median_pixel_filter");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  plan_row_t plan[$];

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    plan.push_back('{1'b1, idx, data, '0, 1'b0, '0});
  endfunction

  function automatic void plan_word(input pix_in_t wd, input bit typed = 1'b0,
                                    input pix_out_t want = '0);
    plan.push_back('{1'b0, '0, '0, wd, typed, want});
  endfunction

  initial begin
    reg_width = WIDTH_RESET;
    reg_height = HEIGHT_RESET;
    reg_window = WIN_RESET;
    reg_mode = 1'b0;
    restart_image();
    foreach (line_mem[i]) line_mem[i] = '0;

    // zero registers act as 1x1 image, 1x1 window: output equals input
    plan_cfg(CFG_IMAGE_WIDTH, 16'h0000);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'h0000);
    plan_cfg(CFG_WINDOW_SIZE, 16'h0000);
    plan_cfg(CFG_FILTER_MODE, 16'h0000);
    plan_word('{ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1});
    plan_word('{ACT_PIXEL, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1});
    plan_word('{ACT_PIXEL, 8'hFF, 8'h00, 8'hA5}, 1'b1, '{8'hFF, 8'h00, 8'hA5, 1'b1});
    // flush while the image is still open: nothing comes out
    plan_word('{ACT_FLUSH, 8'hFF, 8'hFF, 8'hFF});
    // width saturates at its maximum, then a reserved index is ignored
    plan_cfg(CFG_IMAGE_WIDTH, 16'hFFFF);
    plan_cfg(CFG_UNUSED, 16'hFFFF);
    // 2x1 image, window 7 median: even counts average, surplus pixel drains
    plan_cfg(CFG_IMAGE_WIDTH, 16'hF802);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'hE001);
    plan_cfg(CFG_WINDOW_SIZE, 16'hFFFF);
    plan_cfg(CFG_FILTER_MODE, 16'hFFFF);
    plan_word('{ACT_PIXEL, 8'h10, 8'hFF, 8'h00});
    plan_word('{ACT_PIXEL, 8'h31, 8'h00, 8'hFF});
    plan_word('{ACT_PIXEL, 8'h77, 8'h77, 8'h77});
    plan_word('{ACT_FLUSH, 8'h00, 8'h00, 8'h00});
    // 3x2 image, 3x3 mean with clipped corners
    plan_cfg(CFG_IMAGE_WIDTH, 16'd3);
    plan_cfg(CFG_IMAGE_HEIGHT, 16'd2);
    plan_cfg(CFG_WINDOW_SIZE, 16'd3);
    plan_cfg(CFG_FILTER_MODE, 16'd0);
    plan_word('{ACT_PIXEL, 8'hFF, 8'h01, 8'h80});
    plan_word('{ACT_PIXEL, 8'h00, 8'hFE, 8'h7F});
    plan_word('{ACT_PIXEL, 8'hFF, 8'hFF, 8'h00});
    plan_word('{ACT_PIXEL, 8'h12, 8'h34, 8'h56});
    plan_word('{ACT_PIXEL, 8'hFF, 8'h00, 8'hFF});
    plan_word('{ACT_PIXEL, 8'h01, 8'h02, 8'h03});
    repeat (4) plan_word('{ACT_FLUSH, 8'h00, 8'h00, 8'h00});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].wd, plan[i].typed, plan[i].want);
    end

    // extremes: widest row and tallest column on cut frames, largest window
    // on a whole frame
    run_phase(1024, 1, 1, 0, 1, 1'b1);
    run_phase(1, 4096, 3, 1, 1, 1'b1);
    run_phase(7, 7, 7, 0, 1, 1'b0);

    while (words_in < 1050) begin
      if (words_in > 880) calm = 1'b1;
      if ($urandom_range(0, 4) == 0)
        run_phase($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 7),
                  $urandom_range(0, 1), 1, 1'b1);
      else
        run_phase($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 7),
                  $urandom_range(0, 1), $urandom_range(1, 2), 1'b0);
    end

    wait_quiet();
    errors += filtered_q.size();
    $display("Covered %0d input words and %0d filtered words over %0d register writes,",
             words_in, words_out, reg_writes);
    $display("mean and median windows 1..7, clipped borders, flushes and cut frames.");
    if (errors == 0) $display("PASS windowed_mean_median_pixel_filter");
    else $display("FAIL windowed_mean_median_pixel_filter");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mmf_pkg.sv
design/mmf_store.sv
design/mmf_sort.sv
design/mmf_datapath.sv
design/mmf_ctrl.sv
design/windowed_mean_median_pixel_filter.sv
test/windowed_mean_median_pixel_filter_tb.sv
